### src/periodic_telemetry_frame_scheduler_defines.svh
// Assertion macros shared by the telemetry frame scheduler.
`ifndef PERIODIC_TELEMETRY_FRAME_SCHEDULER_DEFINES_SVH
`define PERIODIC_TELEMETRY_FRAME_SCHEDULER_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Checks that a condition implies a consequence in the next cycle.
`define PTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

### src/pts_pkg.sv
// Types and constants of the telemetry frame scheduler.
package pts_pkg;

    localparam logic [28:0] ID_HILO  = 29'h18060800;
    localparam logic [28:0] ID_PACK  = 29'h18070800;
    localparam logic [28:0] ID_TEMP  = 29'h180C0800;
    localparam logic [28:0] ID_INFO  = 29'h18040A00;
    localparam logic [28:0] ID_FAULT = 29'h18FF0E00;
    localparam logic [7:0]  FAULT_SEV = 8'h82;

    localparam logic [2:0] REG_NODE_ID      = 3'd0;
    localparam logic [2:0] REG_SERIAL       = 3'd1;
    localparam logic [2:0] REG_FIRMWARE     = 3'd2;
    localparam logic [2:0] REG_BATTERY_TYPE = 3'd3;
    localparam logic [2:0] REG_FAST_PERIOD  = 3'd4;
    localparam logic [2:0] REG_SLOW_PERIOD  = 3'd5;
    localparam logic [2:0] REG_FAULT_PERIOD = 3'd6;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [15:0]        high_cell_mv;
        logic [15:0]        low_cell_mv;
        logic [15:0]        pack_decivolts;
        logic [7:0]         charge_percent;
        logic signed [15:0] temp_high_decic;
        logic signed [15:0] temp_low_decic;
        logic [7:0]         error_code;
    } pts_tick_t;

    typedef struct packed {
        logic [28:0] frame_id;
        logic [63:0] payload;
        logic        last_frame;
    } pts_frame_t;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [31:0] serial_number;
        logic [15:0] firmware_major_minor;
        logic [15:0] battery_type;
        logic [15:0] fast_period_ms;
        logic [15:0] slow_period_ms;
        logic [15:0] fault_period_ms;
    } pts_cfg_t;

    typedef struct packed {
        logic        fault_due;
        logic        slow_due;
        logic        fast_due;
        logic [15:0] high_cell_mv;
        logic [15:0] low_cell_mv;
        logic [15:0] pack_decivolts;
        logic [7:0]  charge_percent;
        logic [15:0] temp_high;
        logic [15:0] temp_low;
        logic [15:0] temp_mean;
        logic [7:0]  error_code;
        logic [7:0]  rolling;
    } pts_job_t;

endpackage

### src/periodic_telemetry_frame_scheduler.sv
// Top level of the periodic telemetry frame scheduler.
// A tick is accepted in any cycle the job queue has room; ticks can arrive back to back.
// The first frame of a tick passes through the job queue and then the frame queue before it reaches the result ports.
// The frame builder sends one frame per cycle while the frame queue has room; a tick makes up to 5 frames.
// Reset clears the group times, the rolling byte and both queues and loads register defaults.
`include "periodic_telemetry_frame_scheduler_defines.svh"

module periodic_telemetry_frame_scheduler
    import pts_pkg::*;
    #(
        parameter int JOB_DEPTH   = 2,
        parameter int FRAME_DEPTH = 2
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        push,
        output logic        full,
        input  pts_tick_t   tick,
        output logic        empty,
        input  logic        pop,
        output pts_frame_t  frame,
        input  logic        cfg_valid,
        output logic        cfg_ready,
        input  logic [2:0]  cfg_index,
        input  logic [31:0] cfg_data
    );

    pts_cfg_t   cfg_reg;
    pts_cfg_t   cfg_next;
    logic       job_full;
    logic       job_push;
    pts_job_t   job_in;
    pts_job_t   job_head;
    logic       job_empty;
    logic       job_pop;
    logic       frame_full;
    logic       frame_push;
    pts_frame_t frame_in;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NODE_ID:      cfg_next.node_id              = cfg_data[7:0];
                REG_SERIAL:       cfg_next.serial_number        = cfg_data;
                REG_FIRMWARE:     cfg_next.firmware_major_minor = cfg_data[15:0];
                REG_BATTERY_TYPE: cfg_next.battery_type         = cfg_data[15:0];
                REG_FAST_PERIOD:  cfg_next.fast_period_ms       = cfg_data[15:0];
                REG_SLOW_PERIOD:  cfg_next.slow_period_ms       = cfg_data[15:0];
                REG_FAULT_PERIOD: cfg_next.fault_period_ms      = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id              <= 8'd0;
            cfg_reg.serial_number        <= 32'h40000001;
            cfg_reg.firmware_major_minor <= 16'h0004;
            cfg_reg.battery_type         <= 16'h0400;
            cfg_reg.fast_period_ms       <= 16'd100;
            cfg_reg.slow_period_ms       <= 16'd1000;
            cfg_reg.fault_period_ms      <= 16'd5000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pts_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .tick     (tick),
        .full     (full),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    pts_fifo
    #(
        .WIDTH ($bits(pts_job_t)),
        .DEPTH (JOB_DEPTH)
    )
    u_job_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (job_empty)
    );

    pts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job        (job_head),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .frame_full (frame_full),
        .frame_push (frame_push),
        .frame      (frame_in)
    );

    pts_fifo
    #(
        .WIDTH ($bits(pts_frame_t)),
        .DEPTH (FRAME_DEPTH)
    )
    u_frame_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_push),
        .wr_data (frame_in),
        .full    (frame_full),
        .rd_en   (pop),
        .rd_data (frame),
        .empty   (empty)
    );

    `PTS_ASSERT_SAME(a_job_has_frames, job_push, job_in.fast_due || job_in.slow_due || job_in.fault_due)
    `PTS_ASSERT_SAME(a_back_never_idles, !job_empty && !frame_full, frame_push)
    `PTS_ASSERT_NEXT(a_last_frame_queued, frame_push && frame_in.last_frame, !empty)

endmodule

### src/pts_fifo.sv
// Small register FIFO used for the job queue and the frame queue.
module pts_fifo
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 2
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             wr_en,
        input  logic [WIDTH-1:0] wr_data,
        output logic             full,
        input  logic             rd_en,
        output logic [WIDTH-1:0] rd_data,
        output logic             empty
    );

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/pts_front.sv
// Front end: accepts ticks, decides which groups are due and queues a job.
module pts_front
    import pts_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  pts_cfg_t  cfg,
        input  logic      push,
        input  pts_tick_t tick,
        output logic      full,
        input  logic      job_full,
        output logic      job_push,
        output pts_job_t  job
    );

    logic [31:0] fast_last_reg;
    logic [31:0] fast_last_next;
    logic [31:0] slow_last_reg;
    logic [31:0] slow_last_next;
    logic [31:0] fault_last_reg;
    logic [31:0] fault_last_next;
    logic [7:0]  rolling_reg;
    logic [7:0]  rolling_next;
    logic        accept;
    logic        fast_due;
    logic        slow_due;
    logic        fault_due;
    logic [31:0] fast_elapsed;
    logic [31:0] slow_elapsed;
    logic [31:0] fault_elapsed;
    logic [16:0] temp_sum;
    logic [16:0] temp_adj;

    assign full   = job_full;
    assign accept = push && !job_full;

    assign fast_elapsed  = tick.now_ms - fast_last_reg;
    assign slow_elapsed  = tick.now_ms - slow_last_reg;
    assign fault_elapsed = tick.now_ms - fault_last_reg;

    assign fast_due  = (fast_elapsed >= {16'd0, cfg.fast_period_ms});
    assign slow_due  = (slow_elapsed >= {16'd0, cfg.slow_period_ms});
    assign fault_due = (tick.error_code != 8'd0)
                       && (fault_elapsed >= {16'd0, cfg.fault_period_ms});

    // Adding the sign bit before the shift rounds a negative odd sum toward zero.
    assign temp_sum = {tick.temp_high_decic[15], tick.temp_high_decic}
                      + {tick.temp_low_decic[15], tick.temp_low_decic};
    assign temp_adj = temp_sum + {16'd0, temp_sum[16]};

    always_comb
    begin
        job.fault_due      = fault_due;
        job.slow_due       = slow_due;
        job.fast_due       = fast_due;
        job.high_cell_mv   = tick.high_cell_mv;
        job.low_cell_mv    = tick.low_cell_mv;
        job.pack_decivolts = tick.pack_decivolts;
        job.charge_percent = tick.charge_percent;
        job.temp_high      = tick.temp_high_decic;
        job.temp_low       = tick.temp_low_decic;
        job.temp_mean      = temp_adj[16:1];
        job.error_code     = tick.error_code;
        job.rolling        = rolling_reg;
    end

    assign job_push = accept && (fast_due || slow_due || fault_due);

    always_comb
    begin
        fast_last_next  = fast_last_reg;
        slow_last_next  = slow_last_reg;
        fault_last_next = fault_last_reg;
        rolling_next    = rolling_reg;
        if (accept)
        begin
            if (fast_due)
            begin
                fast_last_next = tick.now_ms;
                rolling_next   = rolling_reg + 8'd1;
            end
            if (slow_due)
            begin
                slow_last_next = tick.now_ms;
            end
            if (fault_due)
            begin
                fault_last_next = tick.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_last_reg  <= '0;
            slow_last_reg  <= '0;
            fault_last_reg <= '0;
            rolling_reg    <= '0;
        end
        else
        begin
            fast_last_reg  <= fast_last_next;
            slow_last_reg  <= slow_last_next;
            fault_last_reg <= fault_last_next;
            rolling_reg    <= rolling_next;
        end
    end

endmodule

### src/pts_back.sv
// Back end: walks the frames of the job at the queue head, one frame a cycle while the frame queue has room.
module pts_back
    import pts_pkg::*;
    (
        input  logic       clk,
        input  logic       rst_n,
        input  pts_cfg_t   cfg,
        input  pts_job_t   job,
        input  logic       job_empty,
        output logic       job_pop,
        input  logic       frame_full,
        output logic       frame_push,
        output pts_frame_t frame
    );

    logic [4:0]  sent_reg;
    logic [4:0]  sent_next;
    logic [4:0]  wanted;
    logic [4:0]  remain;
    logic [4:0]  sel;
    logic        last;
    logic [28:0] base;
    logic [63:0] data;

    assign wanted = {job.fault_due, job.slow_due, job.slow_due, job.fast_due, job.fast_due};
    assign remain = wanted & ~sent_reg;
    assign sel    = remain & (~remain + 5'd1);
    assign last   = ((remain & ~sel) == 5'd0);

    assign frame_push = !job_empty && !frame_full;
    assign job_pop    = frame_push && last;

    always_comb
    begin
        case (sel)
            5'b00001:
            begin
                base = ID_HILO;
                data = {job.high_cell_mv, job.low_cell_mv, job.error_code, 8'h00,
                        cfg.battery_type};
            end
            5'b00010:
            begin
                base = ID_PACK;
                data = {job.pack_decivolts, 24'h000000, job.charge_percent,
                        job.charge_percent, job.rolling};
            end
            5'b00100:
            begin
                base = ID_TEMP;
                data = {job.temp_high, job.temp_low, 8'h01, 8'h02, job.temp_mean};
            end
            5'b01000:
            begin
                base = ID_INFO;
                data = {cfg.serial_number, cfg.firmware_major_minor, cfg.battery_type};
            end
            default:
            begin
                base = ID_FAULT;
                data = {FAULT_SEV, 8'h00, job.error_code, 40'h0000000000};
            end
        endcase
    end

    always_comb
    begin
        frame.frame_id   = base | {21'd0, cfg.node_id};
        frame.payload    = data;
        frame.last_frame = last;
    end

    always_comb
    begin
        sent_next = sent_reg;
        if (frame_push)
        begin
            sent_next = last ? 5'd0 : (sent_reg | sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
        end
        else
        begin
            sent_reg <= sent_next;
        end
    end

endmodule

### test/periodic_telemetry_frame_scheduler_tb.sv
// Self-checking testbench for the periodic telemetry frame scheduler.
`timescale 1ns / 100ps

module periodic_telemetry_frame_scheduler_tb;
    import pts_pkg::*;

    localparam int          HALF_PERIOD   = 2;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SEG_COUNT     = 6;
    localparam int          SEG_TICKS     = 33;
    localparam logic [2:0]  REG_UNUSED    = 3'd7;

    class frame_schedule_model;
        pts_cfg_t    cfg;
        logic [31:0] fast_last;
        logic [31:0] slow_last;
        logic [31:0] fault_last;
        logic [7:0]  rolling;
        pts_frame_t  due_frames[$];
        int          mismatches;

        function new();
            cfg.node_id              = 8'h00;
            cfg.serial_number        = 32'h40000001;
            cfg.firmware_major_minor = 16'h0004;
            cfg.battery_type         = 16'h0400;
            cfg.fast_period_ms       = 16'd100;
            cfg.slow_period_ms       = 16'd1000;
            cfg.fault_period_ms      = 16'd5000;
            fast_last  = '0;
            slow_last  = '0;
            fault_last = '0;
            rolling    = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_NODE_ID:      cfg.node_id              = data[7:0];
                REG_SERIAL:       cfg.serial_number        = data;
                REG_FIRMWARE:     cfg.firmware_major_minor = data[15:0];
                REG_BATTERY_TYPE: cfg.battery_type         = data[15:0];
                REG_FAST_PERIOD:  cfg.fast_period_ms       = data[15:0];
                REG_SLOW_PERIOD:  cfg.slow_period_ms       = data[15:0];
                REG_FAULT_PERIOD: cfg.fault_period_ms      = data[15:0];
                default: ;
            endcase
        endfunction

        function void add_frame(logic [28:0] base, logic [63:0] data);
            pts_frame_t f;
            f.frame_id   = base | {21'b0, cfg.node_id};
            f.payload    = data;
            f.last_frame = 1'b0;
            due_frames.push_back(f);
        endfunction

        function void take_tick(pts_tick_t t);
            logic [31:0] fast_since;
            logic [31:0] slow_since;
            logic [31:0] fault_since;
            int          hs;
            int          ls;
            int          mean;
            int          first;
            first       = due_frames.size();
            fast_since  = t.now_ms - fast_last;
            slow_since  = t.now_ms - slow_last;
            fault_since = t.now_ms - fault_last;
            if (fast_since >= {16'b0, cfg.fast_period_ms})
            begin
                fast_last = t.now_ms;
                add_frame(ID_HILO, {t.high_cell_mv, t.low_cell_mv, t.error_code, 8'h00,
                                    cfg.battery_type});
                add_frame(ID_PACK, {t.pack_decivolts, 24'h000000, t.charge_percent,
                                    t.charge_percent, rolling});
                rolling = rolling + 8'd1;
            end
            if (slow_since >= {16'b0, cfg.slow_period_ms})
            begin
                slow_last = t.now_ms;
                hs   = $signed(t.temp_high_decic);
                ls   = $signed(t.temp_low_decic);
                mean = (hs + ls) / 2;
                add_frame(ID_TEMP, {t.temp_high_decic, t.temp_low_decic, 8'h01, 8'h02,
                                    mean[15:0]});
                add_frame(ID_INFO, {cfg.serial_number, cfg.firmware_major_minor,
                                    cfg.battery_type});
            end
            if (t.error_code != 8'h00 && fault_since >= {16'b0, cfg.fault_period_ms})
            begin
                fault_last = t.now_ms;
                add_frame(ID_FAULT, {FAULT_SEV, 8'h00, t.error_code, 40'h0});
            end
            if (due_frames.size() > first)
            begin
                due_frames[due_frames.size() - 1].last_frame = 1'b1;
            end
        endfunction

        function void match_frame(pts_frame_t got);
            pts_frame_t want;
            if (due_frames.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, actual id %h payload %h last %b",
                         $time, got.frame_id, got.payload, got.last_frame);
                mismatches++;
            end
            else
            begin
                want = due_frames.pop_front();
                if (got.frame_id !== want.frame_id)
                begin
                    $display("%0t: frame_id mismatch, expected %h actual %h",
                             $time, want.frame_id, got.frame_id);
                    mismatches++;
                end
                if (got.payload !== want.payload)
                begin
                    $display("%0t: payload mismatch (id %h), expected %h actual %h",
                             $time, want.frame_id, want.payload, got.payload);
                    mismatches++;
                end
                if (got.last_frame !== want.last_frame)
                begin
                    $display("%0t: last_frame mismatch (id %h), expected %b actual %b",
                             $time, want.frame_id, want.last_frame, got.last_frame);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    pts_tick_t   tick_in;
    logic        empty;
    logic        pop;
    pts_frame_t  frame_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_schedule_model model;
    int          send_idle_pct;
    int          pop_idle_pct;
    int          cycles;

    periodic_telemetry_frame_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .tick      (tick_in),
        .empty     (empty),
        .pop       (pop),
        .frame     (frame_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            model.match_frame(frame_out);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[periodic_telemetry_frame_scheduler] ERROR");
            $finish;
        end
    end

    function automatic pts_tick_t tick_of(logic [31:0] now, logic [15:0] hi, logic [15:0] lo,
                                          logic [15:0] pack, logic [7:0] soc,
                                          logic [15:0] th, logic [15:0] tl, logic [7:0] err);
        pts_tick_t t;
        t.now_ms          = now;
        t.high_cell_mv    = hi;
        t.low_cell_mv     = lo;
        t.pack_decivolts  = pack;
        t.charge_percent  = soc;
        t.temp_high_decic = th;
        t.temp_low_decic  = tl;
        t.error_code      = err;
        return t;
    endfunction

    task automatic send_tick(input pts_tick_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        tick_in <= t;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        model.take_tick(t);
        @(negedge clk);
    endtask

    // Bits above the register width carry random junk that the block must drop.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] keep;
        logic [31:0] data;
        case (idx)
            REG_NODE_ID: keep = 32'h000000FF;
            REG_SERIAL:  keep = 32'hFFFFFFFF;
            default:     keep = 32'h0000FFFF;
        endcase
        data = (value & keep) | ($urandom() & ~keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        model.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (model.due_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] now;
        logic [31:0] val[8];
        pts_tick_t   t;
        int          pick;

        model         = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        tick_in       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_NODE_ID;
        cfg_data      = '0;
        cycles        = 0;
        send_idle_pct = 6;
        pop_idle_pct  = 56;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_tick(tick_of(32'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00));
        send_tick(tick_of(32'd99, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'h7FFF, 16'h7FFF,
                          8'h00));
        send_tick(tick_of(32'd100, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 16'h7FFF, 16'h7FFF,
                          8'hFF));
        send_tick(tick_of(32'd1000, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 16'h7FFF, 16'h7FFF,
                          8'h00));
        send_tick(tick_of(32'd5000, 16'h8001, 16'h7FFE, 16'h8000, 8'h64, 16'h8000, 16'h8000,
                          8'h01));
        send_tick(tick_of(32'd5001, 16'h1234, 16'h5678, 16'h9ABC, 8'h55, 16'h0001, 16'hFFFF,
                          8'h80));
        wait_idle();

        write_reg(REG_NODE_ID, 32'hFF);
        write_reg(REG_SERIAL, 32'hFFFFFFFF);
        write_reg(REG_FIRMWARE, 32'hFFFF);
        write_reg(REG_BATTERY_TYPE, 32'hFFFF);
        write_reg(REG_FAST_PERIOD, 32'd1);
        write_reg(REG_SLOW_PERIOD, 32'd1);
        write_reg(REG_FAULT_PERIOD, 32'd1);
        cfg_valid <= 1'b0;

        send_tick(tick_of(32'd5002, 16'hAAAA, 16'h5555, 16'h00FF, 8'hAA, 16'hFFFF, 16'h0000,
                          8'h00));
        send_tick(tick_of(32'd5002, 16'h5555, 16'hAAAA, 16'hFF00, 8'h55, 16'h0000, 16'h0000,
                          8'h01));
        send_tick(tick_of(32'd5003, 16'h0F0F, 16'hF0F0, 16'h1111, 8'h0F, 16'h0003, 16'hFFFA,
                          8'h7F));
        send_tick(tick_of(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'h8000,
                          16'h7FFF, 8'hFF));
        send_tick(tick_of(32'd0, 16'h0001, 16'h0002, 16'h0003, 8'h04, 16'hFFFB, 16'h0000,
                          8'hFE));
        wait_idle();

        write_reg(REG_NODE_ID, 32'h0);
        write_reg(REG_SERIAL, 32'h0);
        write_reg(REG_FIRMWARE, 32'h0);
        write_reg(REG_BATTERY_TYPE, 32'h0);
        write_reg(REG_FAST_PERIOD, 32'd0);
        write_reg(REG_SLOW_PERIOD, 32'd0);
        write_reg(REG_FAULT_PERIOD, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        cfg_valid <= 1'b0;

        send_tick(tick_of(32'd0, 16'h8000, 16'h8000, 16'h8000, 8'h80, 16'h0005, 16'h0000,
                          8'h01));
        send_tick(tick_of(32'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h7F, 16'hFFFF, 16'hFFFF,
                          8'h00));
        send_tick(tick_of(32'h80000000, 16'h0000, 16'hFFFF, 16'hA5A5, 8'h01, 16'h7FFF,
                          16'h8000, 8'h40));

        now = 32'h80000000;
        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 6;
                    pop_idle_pct  = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    pop_idle_pct  = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    pop_idle_pct  = 0;
                end
            endcase
            wait_idle();

            case (seg)
                1:
                begin
                    val[REG_NODE_ID]      = 32'h0;
                    val[REG_SERIAL]       = 32'h0;
                    val[REG_FIRMWARE]     = 32'h0;
                    val[REG_BATTERY_TYPE] = 32'h0;
                    val[REG_FAST_PERIOD]  = 32'd0;
                    val[REG_SLOW_PERIOD]  = 32'd3;
                    val[REG_FAULT_PERIOD] = 32'd0;
                end
                2:
                begin
                    val[REG_NODE_ID]      = 32'hFF;
                    val[REG_SERIAL]       = 32'hFFFFFFFF;
                    val[REG_FIRMWARE]     = 32'hFFFF;
                    val[REG_BATTERY_TYPE] = 32'hFFFF;
                    val[REG_FAST_PERIOD]  = 32'hFFFF;
                    val[REG_SLOW_PERIOD]  = 32'hFFFF;
                    val[REG_FAULT_PERIOD] = 32'hFFFF;
                end
                4:
                begin
                    val[REG_NODE_ID]      = $urandom();
                    val[REG_SERIAL]       = $urandom();
                    val[REG_FIRMWARE]     = $urandom();
                    val[REG_BATTERY_TYPE] = $urandom();
                    val[REG_FAST_PERIOD]  = 32'd1;
                    val[REG_SLOW_PERIOD]  = 32'd2;
                    val[REG_FAULT_PERIOD] = 32'd3;
                end
                default:
                begin
                    val[REG_NODE_ID]      = $urandom();
                    val[REG_SERIAL]       = $urandom();
                    val[REG_FIRMWARE]     = $urandom();
                    val[REG_BATTERY_TYPE] = $urandom();
                    val[REG_FAST_PERIOD]  = $urandom_range(1, 6);
                    val[REG_SLOW_PERIOD]  = $urandom_range(5, 40);
                    val[REG_FAULT_PERIOD] = $urandom_range(5, 60);
                end
            endcase
            for (int idx = REG_NODE_ID; idx <= REG_FAULT_PERIOD; idx++)
            begin
                write_reg(3'(idx), val[idx]);
            end
            if (seg == 3)
            begin
                write_reg(REG_UNUSED, $urandom());
            end
            cfg_valid <= 1'b0;

            for (int n = 0; n < SEG_TICKS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    now = now + $urandom_range(0, 20);
                end
                else if (pick < 9)
                begin
                    now = now + $urandom_range(0, 70000);
                end
                else
                begin
                    now = $urandom();
                end
                t = tick_of(now, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                            8'($urandom()), 16'($urandom()), 16'($urandom()),
                            8'($urandom()));
                if ($urandom_range(0, 1) == 0)
                begin
                    t.error_code = 8'h00;
                end
                send_tick(t);
            end
        end
        wait_idle();

        if (model.mismatches == 0)
        begin
            $display("[periodic_telemetry_frame_scheduler] OK");
        end
        else
        begin
            $display("[periodic_telemetry_frame_scheduler] ERROR");
        end
        $finish;
    end

endmodule

### periodic_telemetry_frame_scheduler.f
+incdir+src
src/pts_pkg.sv
src/pts_fifo.sv
src/pts_front.sv
src/pts_back.sv
src/periodic_telemetry_frame_scheduler.sv
test/periodic_telemetry_frame_scheduler_tb.sv
